@@ rtl/cap_pkg.sv @@
package cap_pkg;

  localparam int QW   = 32;
  localparam int GW   = 31;
  localparam int IDXW = 3;

  localparam logic KIND_HOLD   = 1'b0;
  localparam logic KIND_DIRECT = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic signed [QW-1:0] altitude_target;
    logic signed [QW-1:0] altitude_measured;
    logic signed [QW-1:0] climb_rate_measured;
    logic signed [QW-1:0] rate_min;
    logic signed [QW-1:0] rate_max;
    logic signed [QW-1:0] rate_command;
  } sample_t;

  typedef struct packed {
    logic signed [QW-1:0] throttle_comp;
    logic signed [QW-1:0] commanded_rate;
    logic                 output_clamped;
  } result_t;

  typedef enum logic [IDXW-1:0] {
    REG_ALT_KP         = 3'd0,
    REG_ALT_KI_DT      = 3'd1,
    REG_ALT_INT_LIMIT  = 3'd2,
    REG_ROC_KP         = 3'd3,
    REG_ROC_KI_DT      = 3'd4,
    REG_ROC_INT_LIMIT  = 3'd5,
    REG_MAX_THROTTLE   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ERR_ALT,
    OP_ERR_ROC,
    OP_MUL_KP,
    OP_MUL_KI,
    OP_INT,
    OP_CMD_ALT,
    OP_CMD_DIR,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic inner;
  } dp_cmd_t;

  localparam logic [GW-1:0] ALT_KP_RESET      = 31'd65536;
  localparam logic [GW-1:0] ALT_KI_DT_RESET   = 31'd0;
  localparam logic [GW-1:0] ALT_INT_LIM_RESET = 31'd65536;
  localparam logic [GW-1:0] ROC_KP_RESET      = 31'd65536;
  localparam logic [GW-1:0] ROC_KI_DT_RESET   = 31'd0;
  localparam logic [GW-1:0] ROC_INT_LIM_RESET = 31'd65536;
  localparam logic [GW-1:0] MAX_THROTTLE_RESET = 31'd3277;

endpackage

@@ rtl/cap_datapath.sv @@
module cap_datapath
  import cap_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [IDXW-1:0] wr_index,
  input  logic [GW-1:0]   wr_data,
  input  sample_t         sample,
  input  dp_cmd_t         cmd,
  output result_t         result
);

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  logic [GW-1:0] alt_kp, alt_ki_dt, alt_int_limit;
  logic [GW-1:0] roc_kp, roc_ki_dt, roc_int_limit;
  logic [GW-1:0] max_throttle;

  sample_t                item;
  logic signed [QW-1:0]   err;
  logic signed [2*QW-1:0] prod;
  logic signed [QW-1:0]   p;
  logic signed [QW-1:0]   rate_cmd;
  logic signed [QW-1:0]   alt_integral;
  logic signed [QW-1:0]   roc_integral;

  function automatic logic signed [QW-1:0] sat33(input logic signed [QW:0] v);
    if (v[QW] != v[QW-1]) begin
      return v[QW] ? Q_MIN : Q_MAX;
    end
    return v[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    return sat33(s);
  endfunction

  function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    return sat33(s);
  endfunction

  // floor of the Q16.16 product, then saturate
  function automatic logic signed [QW-1:0] qscale(input logic signed [2*QW-1:0] v);
    logic signed [2*QW-1:0] sh;
    sh = v >>> 16;
    if (sh[2*QW-1:QW-1] != {(QW+1){1'b0}} && sh[2*QW-1:QW-1] != {(QW+1){1'b1}}) begin
      return sh[2*QW-1] ? Q_MIN : Q_MAX;
    end
    return sh[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] clamp_sym(input logic signed [QW-1:0] v,
                                                     input logic [GW-1:0] lim);
    logic signed [QW-1:0] l;
    l = {1'b0, lim};
    if (v > l) begin
      return l;
    end
    if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

  logic signed [QW-1:0] gain_kp, gain_ki;
  logic signed [QW-1:0] gain_mul;
  logic [GW-1:0]        int_lim;
  logic signed [QW-1:0] int_sel;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] int_new;
  logic signed [QW-1:0] sum;
  logic signed [QW-1:0] bounded;
  logic signed [QW-1:0] throttle;

  always_comb begin
    gain_kp  = cmd.inner ? {1'b0, roc_kp} : {1'b0, alt_kp};
    gain_ki  = cmd.inner ? {1'b0, roc_ki_dt} : {1'b0, alt_ki_dt};
    // one multiplier serves both gain products
    gain_mul = (cmd.op == OP_MUL_KI) ? gain_ki : gain_kp;
    int_lim  = cmd.inner ? roc_int_limit : alt_int_limit;
    int_sel  = cmd.inner ? roc_integral : alt_integral;
    q        = qscale(prod);
    int_new  = clamp_sym(sat_add(int_sel, q), int_lim);
    sum      = sat_add(p, int_sel);
    // lower bound is checked first
    if (sum < item.rate_min) begin
      bounded = item.rate_min;
    end else if (sum > item.rate_max) begin
      bounded = item.rate_max;
    end else begin
      bounded = sum;
    end
    throttle = clamp_sym(sum, max_throttle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_kp        <= ALT_KP_RESET;
      alt_ki_dt     <= ALT_KI_DT_RESET;
      alt_int_limit <= ALT_INT_LIM_RESET;
      roc_kp        <= ROC_KP_RESET;
      roc_ki_dt     <= ROC_KI_DT_RESET;
      roc_int_limit <= ROC_INT_LIM_RESET;
      max_throttle  <= MAX_THROTTLE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_ALT_KP:        alt_kp        <= wr_data;
        REG_ALT_KI_DT:     alt_ki_dt     <= wr_data;
        REG_ALT_INT_LIMIT: alt_int_limit <= wr_data;
        REG_ROC_KP:        roc_kp        <= wr_data;
        REG_ROC_KI_DT:     roc_ki_dt     <= wr_data;
        REG_ROC_INT_LIMIT: roc_int_limit <= wr_data;
        REG_MAX_THROTTLE:  max_throttle  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_integral <= '0;
      roc_integral <= '0;
    end else if (cmd.op == OP_INT) begin
      if (cmd.inner) begin
        roc_integral <= int_new;
      end else begin
        alt_integral <= int_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= sample;
    end
    case (cmd.op)
      OP_ERR_ALT: err <= sat_sub(item.altitude_target, item.altitude_measured);
      OP_ERR_ROC: err <= sat_sub(rate_cmd, item.climb_rate_measured);
      OP_MUL_KP:  prod <= err * gain_mul;
      OP_MUL_KI: begin
        p    <= q;
        prod <= err * gain_mul;
      end
      OP_CMD_ALT: rate_cmd <= bounded;
      OP_CMD_DIR: rate_cmd <= item.rate_command;
      OP_OUT: begin
        result.throttle_comp  <= throttle;
        result.commanded_rate <= rate_cmd;
        result.output_clamped <= (throttle != sum);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/cap_controller.sv @@
module cap_controller
  import cap_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  input  logic    sample_kind,
  output logic    sample_stall,
  output logic    result_valid,
  input  logic    result_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE,
    ALT_ERR,
    ALT_MKP,
    ALT_MKI,
    ALT_INT,
    ALT_CMD,
    DIR_CMD,
    ROC_ERR,
    ROC_MKP,
    ROC_MKI,
    ROC_INT,
    ROC_OUT
  } state_t;

  state_t state;
  logic   out_wr;

  // the output register is free unless a beat is still held there
  assign out_wr       = (state == ROC_OUT) && !(result_valid && result_stall);
  assign sample_stall = (state != IDLE);

  always_comb begin
    cmd.load  = (state == IDLE) && sample_valid;
    cmd.op    = OP_NONE;
    cmd.inner = 1'b0;
    case (state)
      ALT_ERR: cmd.op = OP_ERR_ALT;
      ALT_MKP: cmd.op = OP_MUL_KP;
      ALT_MKI: cmd.op = OP_MUL_KI;
      ALT_INT: cmd.op = OP_INT;
      ALT_CMD: cmd.op = OP_CMD_ALT;
      DIR_CMD: cmd.op = OP_CMD_DIR;
      ROC_ERR: cmd.op = OP_ERR_ROC;
      ROC_MKP: begin
        cmd.op    = OP_MUL_KP;
        cmd.inner = 1'b1;
      end
      ROC_MKI: begin
        cmd.op    = OP_MUL_KI;
        cmd.inner = 1'b1;
      end
      ROC_INT: begin
        cmd.op    = OP_INT;
        cmd.inner = 1'b1;
      end
      ROC_OUT: begin
        cmd.op    = out_wr ? OP_OUT : OP_NONE;
        cmd.inner = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (out_wr) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (sample_valid) begin
            state <= (sample_kind == KIND_DIRECT) ? DIR_CMD : ALT_ERR;
          end
        end
        ALT_ERR: state <= ALT_MKP;
        ALT_MKP: state <= ALT_MKI;
        ALT_MKI: state <= ALT_INT;
        ALT_INT: state <= ALT_CMD;
        ALT_CMD: state <= ROC_ERR;
        DIR_CMD: state <= ROC_ERR;
        ROC_ERR: state <= ROC_MKP;
        ROC_MKP: state <= ROC_MKI;
        ROC_MKI: state <= ROC_INT;
        ROC_INT: state <= ROC_OUT;
        ROC_OUT: begin
          if (out_wr) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> state == ALT_ERR || state == DIR_CMD)
    else $error("accepted sample did not start a sequence");

  a_held_result_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ROC_OUT && result_valid && result_stall |=> state == ROC_OUT)
    else $error("result overwritten while held");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ROC_OUT)
    else $error("result valid raised outside output step");

  a_taken_drops: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && state != ROC_OUT |=> !result_valid)
    else $error("result repeated after being taken");

endmodule

@@ rtl/cascaded_altitude_pi_controller_top.sv @@
// Cascaded altitude / climb-rate PI controller, one sample per beat on the sample
// channel and one result beat per sample. A sample is taken only when the block is
// idle; after acceptance an altitude-hold sample steps through ALT_ERR to ALT_CMD and
// then ROC_ERR to ROC_OUT, and a direct-command sample through DIR_CMD and ROC_ERR to
// ROC_OUT, as the controller steps both stages through one shared 32x32 multiplier and
// its saturating adders. The result sits in an output register, so the next sample can
// be taken while it waits; if it is still waiting when the next result is ready, the
// controller holds in its output step until that beat is taken.
// Gain and limit registers reset to their defaults; the user writes them through wr_en, wr_index
// and wr_data (low 31 bits) only while no sample is in flight, which the block does not enforce.
module cascaded_altitude_pi_controller_top
  import cap_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [IDXW-1:0] wr_index,
  input  logic [GW-1:0]   wr_data,
  input  logic            sample_valid,
  output logic            sample_stall,
  input  sample_t         sample,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result
);

  dp_cmd_t cmd;

  cap_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_kind  (sample.kind),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  cap_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sample   (sample),
    .cmd      (cmd),
    .result   (result)
  );

endmodule

@@ test/cascaded_altitude_pi_controller_checker.sv @@
`timescale 1ns / 100ps

module cascaded_altitude_pi_controller_checker
  import cap_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [IDXW-1:0] wr_index,
  input  logic [GW-1:0]   wr_data,
  input  logic            sample_valid,
  input  logic            sample_stall,
  input  sample_t         sample,
  input  logic            result_valid,
  input  logic            result_stall,
  input  result_t         result,
  output int              mismatches,
  output int              outstanding,
  output int              results_checked,
  output int              clamp_hits
);

  localparam longint Q_HI        = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_LO        = -Q_HI - 1;

  logic [GW-1:0]        outer_kp, outer_ki, outer_lim;
  logic [GW-1:0]        inner_kp, inner_ki, inner_lim;
  logic [GW-1:0]        throttle_lim;
  logic signed [QW-1:0] outer_acc, inner_acc;

  result_t due_corrections[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_clamped = 0;

  function automatic longint saturate_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // exact product, then drop 16 fraction bits (floor)
  function automatic longint scaled_product(longint v, logic [GW-1:0] g);
    longint p;
    p = v * longint'(g);
    return saturate_q(p >>> 16);
  endfunction

  function automatic longint clamp_both_ways(longint v, logic [GW-1:0] lim);
    longint l;
    l = longint'(lim);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic result_t next_correction(sample_t s);
    longint  cmd, err, prop, total, acc, limited;
    result_t r;
    if (s.kind == KIND_DIRECT) begin
      cmd = longint'(s.rate_command);
    end else begin
      err  = saturate_q(longint'(s.altitude_target) - longint'(s.altitude_measured));
      prop = scaled_product(err, outer_kp);
      acc  = saturate_q(longint'(outer_acc) + scaled_product(err, outer_ki));
      acc  = clamp_both_ways(acc, outer_lim);
      outer_acc = acc[QW-1:0];
      total = saturate_q(prop + acc);
      // lower bound is checked first: with inverted bounds a total below rate_min gives rate_min, else rate_max
      if (total < longint'(s.rate_min)) cmd = longint'(s.rate_min);
      else if (total > longint'(s.rate_max)) cmd = longint'(s.rate_max);
      else cmd = total;
    end
    err  = saturate_q(cmd - longint'(s.climb_rate_measured));
    prop = scaled_product(err, inner_kp);
    acc  = saturate_q(longint'(inner_acc) + scaled_product(err, inner_ki));
    acc  = clamp_both_ways(acc, inner_lim);
    inner_acc = acc[QW-1:0];
    total   = saturate_q(prop + acc);
    limited = clamp_both_ways(total, throttle_lim);
    r.throttle_comp  = limited[QW-1:0];
    r.commanded_rate = cmd[QW-1:0];
    r.output_clamped = (limited != total);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      outer_kp     = ALT_KP_RESET;
      outer_ki     = ALT_KI_DT_RESET;
      outer_lim    = ALT_INT_LIM_RESET;
      inner_kp     = ROC_KP_RESET;
      inner_ki     = ROC_KI_DT_RESET;
      inner_lim    = ROC_INT_LIM_RESET;
      throttle_lim = MAX_THROTTLE_RESET;
      outer_acc    = '0;
      inner_acc    = '0;
      due_corrections.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ALT_KP:        outer_kp = wr_data;
          REG_ALT_KI_DT:     outer_ki = wr_data;
          REG_ALT_INT_LIMIT: outer_lim = wr_data;
          REG_ROC_KP:        inner_kp = wr_data;
          REG_ROC_KI_DT:     inner_ki = wr_data;
          REG_ROC_INT_LIMIT: inner_lim = wr_data;
          REG_MAX_THROTTLE:  throttle_lim = wr_data;
          default: ;
        endcase
      end
      // the result beat always belongs to an older sample, so pop before push
      if (result_valid && !result_stall) begin
        if (due_corrections.size() == 0) begin
          $error("result beat with no sample waiting for it");
          n_errors++;
        end else begin
          want = due_corrections.pop_front();
          n_checked++;
          if (result.output_clamped === 1'b1) n_clamped++;
          if (result.throttle_comp !== want.throttle_comp) begin
            $error("throttle_comp: expected %0d, got %0d",
                   want.throttle_comp, result.throttle_comp);
            n_errors++;
          end
          if (result.commanded_rate !== want.commanded_rate) begin
            $error("commanded_rate: expected %0d, got %0d",
                   want.commanded_rate, result.commanded_rate);
            n_errors++;
          end
          if (result.output_clamped !== want.output_clamped) begin
            $error("output_clamped: expected %0b, got %0b",
                   want.output_clamped, result.output_clamped);
            n_errors++;
          end
        end
      end
      if (sample_valid && !sample_stall) due_corrections.push_back(next_correction(sample));
    end
    mismatches      <= n_errors;
    outstanding     <= due_corrections.size();
    results_checked <= n_checked;
    clamp_hits      <= n_clamped;
  end

endmodule

@@ test/cascaded_altitude_pi_controller_top_test.sv @@
`timescale 1ns / 100ps

module cascaded_altitude_pi_controller_top_test
  import cap_pkg::*;
();

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE         = 24;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 210;

  localparam logic [IDXW-1:0]   REG_UNUSED  = 3'd7;
  localparam logic signed [QW-1:0] Q_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_BOTTOM = 32'sh8000_0000;
  localparam logic signed [QW-1:0] Q_ONE    = 32'sh0001_0000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            wr_en = 1'b0;
  logic [IDXW-1:0] wr_index = '0;
  logic [GW-1:0]   wr_data = '0;
  logic            sample_valid = 1'b0;
  logic            sample_stall;
  sample_t         sample = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  result_t         result;

  int mismatches, outstanding, results_checked, clamp_hits;
  int n_hold = 0;
  int n_direct = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  bit long_hold_req = 1'b0;

  cascaded_altitude_pi_controller_top uut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  cascaded_altitude_pi_controller_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample          (sample),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .clamp_hits      (clamp_hits)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || wr_en || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("[cascaded_altitude_pi_controller_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls in spans of varying character, plus one long hold-off on request
  initial begin : receiver
    int mode, span, k;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= k[2];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic sample_t make_sample(logic kind, logic signed [QW-1:0] tgt,
                                          logic signed [QW-1:0] meas,
                                          logic signed [QW-1:0] climb,
                                          logic signed [QW-1:0] lo,
                                          logic signed [QW-1:0] hi,
                                          logic signed [QW-1:0] cmd);
    sample_t s;
    s.kind                = kind;
    s.altitude_target     = tgt;
    s.altitude_measured   = meas;
    s.climb_rate_measured = climb;
    s.rate_min            = lo;
    s.rate_max            = hi;
    s.rate_command        = cmd;
    return s;
  endfunction

  function automatic logic signed [QW-1:0] random_q();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return Q_TOP;
          1: return Q_BOTTOM;
          2: return '0;
          3: return -1;
          default: return Q_ONE;
        endcase
      end
      default: return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    logic signed [QW-1:0] a, b;
    s.kind                = ($urandom_range(0, 9) < 7) ? KIND_HOLD : KIND_DIRECT;
    s.altitude_target     = random_q();
    s.altitude_measured   = random_q();
    s.climb_rate_measured = random_q();
    s.rate_command        = random_q();
    a = -int'($urandom_range(0, 32'h0008_0000));
    b = int'($urandom_range(0, 32'h0008_0000));
    case ($urandom_range(0, 9))
      7: begin
        s.rate_min = b;
        s.rate_max = a;
      end
      8, 9: begin
        s.rate_min = random_q();
        s.rate_max = random_q();
      end
      default: begin
        s.rate_min = a;
        s.rate_max = b;
      end
    endcase
    return s;
  endfunction

  function automatic logic [GW-1:0] random_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return GW'($urandom);
      default: return GW'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [GW-1:0] random_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return GW'($urandom);
      default: return GW'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic offer(input sample_t s);
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (s.kind == KIND_HOLD) n_hold++;
    else n_direct++;
  endtask

  task automatic run_random(input int count);
    int burst_left, gap;
    burst_left = $urandom_range(1, 30);
    repeat (count) begin
      offer(random_sample());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap != 0) begin
          sample_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [GW-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [GW-1:0] akp, aki, alim, rkp, rki, rlim, tlim);
    write_reg(REG_ALT_KP, akp);
    write_reg(REG_ALT_KI_DT, aki);
    write_reg(REG_ALT_INT_LIMIT, alim);
    write_reg(REG_ROC_KP, rkp);
    write_reg(REG_ROC_KI_DT, rki);
    write_reg(REG_ROC_INT_LIMIT, rlim);
    write_reg(REG_MAX_THROTTLE, tlim);
    wr_en <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains: saturated errors, both bound orders, output exactly at the clamp
    offer(make_sample(KIND_HOLD, Q_TOP, Q_BOTTOM, 0, Q_BOTTOM, Q_TOP, 0));
    offer(make_sample(KIND_HOLD, Q_BOTTOM, Q_TOP, Q_TOP, Q_BOTTOM, Q_TOP, Q_TOP));
    offer(make_sample(KIND_HOLD, 0, 0, 0, Q_BOTTOM, Q_TOP, 0));
    offer(make_sample(KIND_HOLD, 5 * Q_ONE, 0, 0, 10 * Q_ONE, -10 * Q_ONE, 0));
    offer(make_sample(KIND_HOLD, 20 * Q_ONE, 0, 0, 10 * Q_ONE, -10 * Q_ONE, 0));
    offer(make_sample(KIND_HOLD, 3 * Q_ONE, 0, Q_ONE, -Q_ONE, Q_ONE, 0));
    offer(make_sample(KIND_DIRECT, Q_BOTTOM, Q_TOP, Q_BOTTOM, Q_TOP, Q_BOTTOM, Q_TOP));
    offer(make_sample(KIND_DIRECT, Q_TOP, Q_BOTTOM, Q_TOP, Q_TOP, Q_BOTTOM, Q_BOTTOM));
    offer(make_sample(KIND_DIRECT, 0, 0, 0, 0, 0, 3277));
    offer(make_sample(KIND_DIRECT, 0, 0, 0, 0, 0, -3277));
    offer(make_sample(KIND_DIRECT, 0, 0, 0, 0, 0, 3278));
    offer(make_sample(KIND_DIRECT, 0, 0, 0, 0, 0, -3278));
    offer(make_sample(KIND_DIRECT, 0, 0, 0, 0, 0, -1));
    offer(make_sample(KIND_HOLD, 0, 1, 0, Q_BOTTOM, Q_TOP, 0));
    drain();

    // a write to the unused index must leave every gain alone
    write_reg(REG_UNUSED, '1);
    wr_en <= 1'b0;
    offer(make_sample(KIND_DIRECT, 0, 0, 0, 0, 0, 3277));
    drain();

    program_gains('1, '1, '1, '1, '1, '1, '1);
    offer(make_sample(KIND_HOLD, Q_TOP, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_TOP, 0));
    offer(make_sample(KIND_HOLD, Q_BOTTOM, Q_TOP, Q_TOP, Q_BOTTOM, Q_TOP, 0));
    offer(make_sample(KIND_DIRECT, 0, 0, -1, 0, 0, 1));
    drain();

    program_gains('0, '0, '0, '0, '0, '0, '0);
    offer(make_sample(KIND_HOLD, Q_TOP, 0, 0, -Q_ONE, Q_ONE, 0));
    offer(make_sample(KIND_DIRECT, 0, 0, Q_ONE, 0, 0, Q_BOTTOM));
    drain();

    for (k = 0; k < RANDOM_PHASES; k++) begin
      program_gains(random_gain(), random_gain(), random_limit(), random_gain(),
                    random_gain(), random_limit(), random_limit());
      if (k == 2) begin
        // back-to-back beats while the result side holds off
        long_hold_req = 1'b1;
        repeat (48) offer(random_sample());
      end
      if (k == 5) begin
        run_random(PHASE_ITEMS / 2);
        drain();
      end
      run_random(PHASE_ITEMS);
      drain();
    end

    $display("drove %0d samples (%0d altitude hold, %0d direct) over %0d gain settings",
             n_hold + n_direct, n_hold, n_direct, n_settings);
    $display("checked %0d results, %0d of them at the throttle clamp",
             results_checked, clamp_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[cascaded_altitude_pi_controller_top] OK");
    end else begin
      $display("[cascaded_altitude_pi_controller_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cap_pkg.sv
rtl/cap_datapath.sv
rtl/cap_controller.sv
rtl/cascaded_altitude_pi_controller_top.sv
test/cascaded_altitude_pi_controller_checker.sv
test/cascaded_altitude_pi_controller_top_test.sv
